// ===== rtl/moving_average_object_segmenter_unit_macros.svh =====
// Assertion macros for the moving-average object segmenter.
// Used by the top level; needs clk and rst_n in the scope of the use.
`ifndef MOVING_AVERAGE_OBJECT_SEGMENTER_UNIT_MACROS_SVH
`define MOVING_AVERAGE_OBJECT_SEGMENTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MASEG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MASEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/maseg_pkg.sv =====
// Shared types and constants for the moving-average object segmenter.
// No dependencies; used by maseg_result_queue, the top level and the testbench.
package maseg_pkg;

  localparam int ANGLE_W = 8;
  localparam int DIST_W  = 12;
  localparam int COUNT_W = 4;

  localparam logic [DIST_W-1:0] THRESH_RESET = 12'd50;

  localparam logic KIND_OBJECT = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  // Result queue: a final reading may push two records while one still waits.
  localparam int QUEUE_DEPTH = 3;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
    logic               final_reading;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] stop_angle;
    logic [COUNT_W-1:0] object_count;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== rtl/maseg_result_queue.sv =====
// Three-entry result queue that accepts up to two records per cycle.
// Depends on maseg_pkg for the record type and the push control struct.
module maseg_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  maseg_pkg::push_t    push,
  input  maseg_pkg::out_item_t push_data0,
  input  maseg_pkg::out_item_t push_data1,
  input  logic                pop,
  output maseg_pkg::out_item_t head,
  output logic                not_empty,
  output logic                room
);

  maseg_pkg::out_item_t ent_r   [maseg_pkg::QUEUE_DEPTH];
  maseg_pkg::out_item_t ent_nxt [maseg_pkg::QUEUE_DEPTH];
  logic [maseg_pkg::QCNT_W-1:0] count_r, count_nxt, base;

  always_comb begin
    base = count_r - maseg_pkg::QCNT_W'(pop);
    for (int i = 0; i < maseg_pkg::QUEUE_DEPTH; i++) begin
      if (pop && i < maseg_pkg::QUEUE_DEPTH - 1) begin
        ent_nxt[i] = ent_r[i+1];
      end else begin
        ent_nxt[i] = ent_r[i];
      end
      if (push.first && base == maseg_pkg::QCNT_W'(i)) begin
        ent_nxt[i] = push_data0;
      end
      if (push.second && base + 1'b1 == maseg_pkg::QCNT_W'(i)) begin
        ent_nxt[i] = push_data1;
      end
    end
    count_nxt = base + maseg_pkg::QCNT_W'(push.first) + maseg_pkg::QCNT_W'(push.second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < maseg_pkg::QUEUE_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  assign head      = ent_r[0];
  assign not_empty = (count_r != '0);
  // Two free slots once this cycle's transfer out has left.
  assign room      = (base <= maseg_pkg::QCNT_W'(1));

endmodule

// ===== rtl/moving_average_object_segmenter_unit.sv =====
// Moving-average object segmenter: top level.
// Throughput: one reading per cycle while the queue has room; the window sum is
// kept running, so each reading costs one subtract, one add and two compares.
// Records leave one a cycle while out_ready is high. Reset (synchronous, rst_n
// low) clears the window, sum, fill, object state and queue, and sets the
// threshold to 50. Depends on maseg_pkg and maseg_result_queue.
`include "moving_average_object_segmenter_unit_macros.svh"

module moving_average_object_segmenter_unit #(
  parameter int WINDOW      = 5,
  parameter int MAX_OBJECTS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  maseg_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output maseg_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [maseg_pkg::DIST_W-1:0] cfg_data
);

  localparam int SUM_W  = maseg_pkg::DIST_W + $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [SUM_W-1:0] LIMIT_RESET = SUM_W'(maseg_pkg::THRESH_RESET) * SUM_W'(WINDOW);

  logic [maseg_pkg::DIST_W-1:0]  dw_r  [WINDOW];
  logic [maseg_pkg::DIST_W-1:0]  dw_nxt[WINDOW];
  logic [maseg_pkg::ANGLE_W-1:0] aw_r  [WINDOW];
  logic [maseg_pkg::ANGLE_W-1:0] aw_nxt[WINDOW];
  logic [SUM_W-1:0]   sum_r, sum_nxt, limit_r;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               inside_r, inside_nxt;
  logic [maseg_pkg::ANGLE_W-1:0] start_r, start_nxt;
  logic [maseg_pkg::COUNT_W-1:0] found_r, found_nxt;

  logic accept, pop, q_room;
  logic full, evaluate, do_open, do_close, fin_close;
  logic inside_mid;
  logic [maseg_pkg::ANGLE_W-1:0] start_mid;
  logic [maseg_pkg::COUNT_W-1:0] found_mid, found_end;
  maseg_pkg::push_t     push;
  maseg_pkg::out_item_t rec_close, rec_fin, rec_done, push0, push1;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_room;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    // Window after the shift; the oldest entry becomes index one of the old one.
    for (int k = 0; k < WINDOW - 1; k++) begin
      dw_nxt[k] = dw_r[k+1];
      aw_nxt[k] = aw_r[k+1];
    end
    dw_nxt[WINDOW-1] = in_data.distance;
    aw_nxt[WINDOW-1] = in_data.angle;
    sum_nxt  = sum_r - SUM_W'(dw_r[0]) + SUM_W'(in_data.distance);
    fill_nxt = (fill_r < FILL_W'(WINDOW)) ? fill_r + 1'b1 : fill_r;
    full     = (fill_nxt == FILL_W'(WINDOW));
    evaluate = full && (found_r < maseg_pkg::COUNT_W'(MAX_OBJECTS));
    do_open  = evaluate && (sum_nxt < limit_r) && !inside_r;
    do_close = evaluate && (sum_nxt > limit_r) && inside_r;

    inside_mid = do_open ? 1'b1 : (do_close ? 1'b0 : inside_r);
    start_mid  = do_open ? aw_r[1] : start_r;
    found_mid  = found_r + maseg_pkg::COUNT_W'(do_close);
    fin_close  = in_data.final_reading && inside_mid;
    found_end  = found_mid + maseg_pkg::COUNT_W'(fin_close);

    rec_close = '{kind: maseg_pkg::KIND_OBJECT, start_angle: start_r,
                  stop_angle: aw_r[1], object_count: found_mid,
                  last_of_run: !in_data.final_reading};
    rec_fin   = '{kind: maseg_pkg::KIND_OBJECT, start_angle: start_mid,
                  stop_angle: in_data.angle, object_count: found_end,
                  last_of_run: 1'b0};
    rec_done  = '{kind: maseg_pkg::KIND_DONE, start_angle: '0, stop_angle: '0,
                  object_count: found_end, last_of_run: 1'b1};

    // A close from the window and a close at the final reading never coincide.
    push.first  = accept && (do_close || in_data.final_reading);
    push.second = accept && in_data.final_reading && (do_close || fin_close);
    if (do_close) begin
      push0 = rec_close;
    end else if (fin_close) begin
      push0 = rec_fin;
    end else begin
      push0 = rec_done;
    end
    push1 = rec_done;

    inside_nxt = inside_mid;
    start_nxt  = start_mid;
    found_nxt  = found_mid;
    if (in_data.final_reading) begin
      for (int k = 0; k < WINDOW; k++) begin
        dw_nxt[k] = '0;
        aw_nxt[k] = '0;
      end
      sum_nxt    = '0;
      fill_nxt   = '0;
      inside_nxt = 1'b0;
      start_nxt  = '0;
      found_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        dw_r[k] <= '0;
        aw_r[k] <= '0;
      end
      sum_r    <= '0;
      fill_r   <= '0;
      inside_r <= 1'b0;
      start_r  <= '0;
      found_r  <= '0;
    end else if (accept) begin
      for (int k = 0; k < WINDOW; k++) begin
        dw_r[k] <= dw_nxt[k];
        aw_r[k] <= aw_nxt[k];
      end
      sum_r    <= sum_nxt;
      fill_r   <= fill_nxt;
      inside_r <= inside_nxt;
      start_r  <= start_nxt;
      found_r  <= found_nxt;
    end
  end

  // The threshold is held pre-multiplied by the window length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= SUM_W'(cfg_data) * SUM_W'(WINDOW);
    end
  end

  maseg_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data0 (push0),
    .push_data1 (push1),
    .pop        (pop),
    .head       (out_data),
    .not_empty  (out_valid),
    .room       (q_room)
  );

  `MASEG_ASSERT_NOW(a_done_zero_angles, out_valid && out_data.kind == maseg_pkg::KIND_DONE, out_data.start_angle == '0 && out_data.stop_angle == '0 && out_data.last_of_run, "done record carries angles or lacks the run end mark")
  `MASEG_ASSERT_NEXT(a_final_gives_result, accept && in_data.final_reading, out_valid, "final reading left no record")
  `MASEG_ASSERT_NEXT(a_final_clears_sweep, accept && in_data.final_reading, fill_r == '0 && !inside_r && found_r == '0 && sum_r == '0, "sweep state not cleared after final reading")
  `MASEG_ASSERT_NOW(a_open_below_limit, inside_r, found_r < maseg_pkg::COUNT_W'(MAX_OBJECTS), "object open at the object limit")

endmodule

// ===== test/moving_average_object_segmenter_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for moving_average_object_segmenter_unit.
// Holds its own model of the window segmenter to predict the records and
// drives the reading, record and threshold channels. Depends on maseg_pkg.
module moving_average_object_segmenter_unit_test;

  localparam int WIN     = 5;
  localparam int MAX_OBJ = 10;
  localparam int PHASE_ITEMS = 300;

  // Predicts the object and done records from the accepted readings and
  // compares them with the records that the block hands over.
  class segment_record_checker;
    maseg_pkg::out_item_t          expected_records[$];
    logic [maseg_pkg::DIST_W-1:0]  near_threshold;
    logic [maseg_pkg::DIST_W-1:0]  dist_win[WIN];
    logic [maseg_pkg::ANGLE_W-1:0] angle_win[WIN];
    int unsigned                   fill;
    bit                            in_object;
    logic [maseg_pkg::ANGLE_W-1:0] open_start;
    logic [maseg_pkg::COUNT_W-1:0] found;
    int unsigned                   mismatches;

    function new();
      near_threshold = maseg_pkg::THRESH_RESET;
      mismatches = 0;
      clear_sweep();
    endfunction

    function void clear_sweep();
      for (int i = 0; i < WIN; i++) begin
        dist_win[i] = '0;
        angle_win[i] = '0;
      end
      fill = 0;
      in_object = 1'b0;
      open_start = '0;
      found = '0;
    endfunction

    function void push_record(logic kind, logic [maseg_pkg::ANGLE_W-1:0] start_a,
                              logic [maseg_pkg::ANGLE_W-1:0] stop_a,
                              logic [maseg_pkg::COUNT_W-1:0] count);
      maseg_pkg::out_item_t rec;
      rec.kind = kind;
      rec.start_angle = start_a;
      rec.stop_angle = stop_a;
      rec.object_count = count;
      rec.last_of_run = 1'b0;
      expected_records.push_back(rec);
    endfunction

    function void note_reading(maseg_pkg::in_item_t rd);
      logic [16:0]          sum;
      logic [16:0]          limit;
      int                   queued_before;
      maseg_pkg::out_item_t tail;
      queued_before = expected_records.size();
      for (int i = 0; i < WIN - 1; i++) begin
        dist_win[i] = dist_win[i+1];
        angle_win[i] = angle_win[i+1];
      end
      dist_win[WIN-1] = rd.distance;
      angle_win[WIN-1] = rd.angle;
      if (fill < WIN) fill++;
      if (fill >= WIN && found < MAX_OBJ) begin
        sum = '0;
        limit = 17'(near_threshold) * 17'(WIN);
        for (int i = 0; i < WIN; i++) sum += 17'(dist_win[i]);
        if (sum < limit && !in_object) begin
          in_object = 1'b1;
          open_start = angle_win[0];
        end else if (sum > limit && in_object) begin
          in_object = 1'b0;
          found++;
          push_record(maseg_pkg::KIND_OBJECT, open_start, angle_win[0], found);
        end
      end
      if (rd.final_reading) begin
        // An object still open at the end of the sweep closes at this angle.
        if (in_object) begin
          in_object = 1'b0;
          found++;
          push_record(maseg_pkg::KIND_OBJECT, open_start, rd.angle, found);
        end
        push_record(maseg_pkg::KIND_DONE, '0, '0, found);
        clear_sweep();
      end
      if (expected_records.size() > queued_before) begin
        tail = expected_records.pop_back();
        tail.last_of_run = 1'b1;
        expected_records.push_back(tail);
      end
    endfunction

    function void check_record(maseg_pkg::out_item_t got);
      maseg_pkg::out_item_t want;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: record with none expected: kind %0d start %0d stop %0d count %0d last %0d",
                   got.kind, got.start_angle, got.stop_angle, got.object_count, got.last_of_run);
        return;
      end
      want = expected_records.pop_front();
      if (got.kind !== want.kind || got.start_angle !== want.start_angle ||
          got.stop_angle !== want.stop_angle || got.object_count !== want.object_count ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: record mismatch at %0t", $realtime);
          $display("  expected kind %0d start %0d stop %0d count %0d last %0d",
                   want.kind, want.start_angle, want.stop_angle, want.object_count,
                   want.last_of_run);
          $display("  actual   kind %0d start %0d stop %0d count %0d last %0d",
                   got.kind, got.start_angle, got.stop_angle, got.object_count,
                   got.last_of_run);
        end
      end
    endfunction

    function int pending();
      return expected_records.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  maseg_pkg::in_item_t           in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  maseg_pkg::out_item_t          out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [maseg_pkg::DIST_W-1:0]  cfg_data  = '0;

  segment_record_checker sb = new();
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  moving_average_object_segmenter_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("moving_average_object_segmenter_unit verification failed");
    $finish;
  end

  // Both transfers are taken from the values held at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_reading(in_data);
      if (out_valid && out_ready) sb.check_record(out_data);
    end
  end

  // The receiver changes its stall pattern every stretch and holds off
  // completely for two long windows so that the block backs up.
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned cycle;
    bit          hold;
    cycle = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode = $urandom_range(3, 0);
      stretch = $urandom_range(200, 32);
      repeat (stretch) begin
        cycle++;
        hold = (cycle >= 1000 && cycle < 1400) || (cycle >= 4000 && cycle < 4300);
        if (hold) out_ready <= 1'b0;
        else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(1, 0) == 0);
            2: out_ready <= ($urandom_range(4, 0) == 0);
            default: out_ready <= cycle[0];
          endcase
        end
        @(posedge clk);
      end
    end
  end

  task automatic send_reading(input maseg_pkg::in_item_t rd);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 60)
                                               : $urandom_range(40, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= rd;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic drain_records();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [maseg_pkg::DIST_W-1:0] value);
    drain_records();
    // Idle cycles separate the last transfer from the register write.
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sb.near_threshold = value;
  endtask

  function automatic logic [maseg_pkg::DIST_W-1:0] pick_distance(
      int unsigned level, logic [maseg_pkg::DIST_W-1:0] thr);
    if (level == 0) begin
      if (thr == 0 || $urandom_range(7, 0) == 0) return '0;
      return maseg_pkg::DIST_W'($urandom_range(thr - 1, 0));
    end
    if (level == 1) begin
      if (thr == 12'hFFF || $urandom_range(7, 0) == 0) return 12'hFFF;
      return maseg_pkg::DIST_W'($urandom_range(4095, thr + 1));
    end
    if (level == 2) return thr;
    return maseg_pkg::DIST_W'($urandom_range(4095, 0));
  endfunction

  // One sweep: runs of near, far and at-threshold readings, with noise, and the final flag on the last.
  task automatic run_sweep(input logic [maseg_pkg::DIST_W-1:0] thr);
    maseg_pkg::in_item_t rd;
    int unsigned kind_sel;
    int unsigned len;
    int unsigned run_min;
    int unsigned run_max;
    int unsigned run_left;
    int unsigned level;
    int unsigned ang;
    bit          noisy;
    kind_sel = $urandom_range(9, 0);
    noisy = (kind_sel == 2);
    run_min = 1;
    run_max = 12;
    case (kind_sel)
      0: len = $urandom_range(4, 1);
      1: begin
        len = $urandom_range(160, 80);
        run_min = 5;
        run_max = 7;
      end
      2: len = $urandom_range(40, 5);
      default: len = $urandom_range(60, 6);
    endcase
    ang = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(180, 0);
    level = $urandom_range(1, 0);
    run_left = $urandom_range(run_max, run_min);
    for (int k = 0; k < len; k++) begin
      if (run_left == 0) begin
        level = ($urandom_range(9, 0) == 0) ? 2 : (level == 0 ? 1 : 0);
        run_left = $urandom_range(run_max, run_min);
      end
      run_left--;
      rd.angle = maseg_pkg::ANGLE_W'(noisy ? $urandom_range(180, 0) : ang);
      rd.distance = pick_distance((noisy || $urandom_range(29, 0) == 0) ? 3 : level, thr);
      rd.final_reading = (k == len - 1);
      send_reading(rd);
      ang = ang + $urandom_range(4, 0);
      if (ang > 180) ang = 180;
    end
  endtask

  initial begin
    logic [maseg_pkg::DIST_W-1:0] thr;
    int unsigned                  sweeps;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset threshold: a final reading into an empty
    // window, an object opened and closed, equality at the threshold, and an
    // object closed by the final reading followed by the done record.
    send_reading('{angle: 8'd0, distance: 12'd0, final_reading: 1'b1});
    for (int a = 0; a < 5; a++)
      send_reading('{angle: maseg_pkg::ANGLE_W'(a), distance: 12'd0, final_reading: 1'b0});
    send_reading('{angle: 8'd180, distance: 12'hFFF, final_reading: 1'b0});
    send_reading('{angle: 8'd100, distance: 12'hFFF, final_reading: 1'b1});
    for (int a = 10; a < 15; a++)
      send_reading('{angle: maseg_pkg::ANGLE_W'(a), distance: maseg_pkg::THRESH_RESET,
                     final_reading: (a == 14)});
    for (int a = 20; a < 24; a++)
      send_reading('{angle: maseg_pkg::ANGLE_W'(a), distance: 12'd10, final_reading: 1'b0});
    send_reading('{angle: 8'd180, distance: 12'd10, final_reading: 1'b1});
    send_reading('{angle: 8'd128, distance: 12'hAAA, final_reading: 1'b0});
    send_reading('{angle: 8'd127, distance: 12'h555, final_reading: 1'b1});

    items_sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: thr = 12'd0;
        1: thr = 12'hFFF;
        2: thr = 12'd819;
        3: thr = maseg_pkg::DIST_W'($urandom_range(4095, 0));
        4: thr = maseg_pkg::DIST_W'($urandom_range(200, 1));
        default: thr = maseg_pkg::THRESH_RESET;
      endcase
      write_threshold(thr);
      sweeps = 0;
      while (items_sent < (ph + 1) * PHASE_ITEMS) begin
        run_sweep(thr);
        sweeps++;
        if (sweeps % 7 == 0) drain_records();
      end
    end

    drain_records();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) $display("ERROR: %0d records never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("moving_average_object_segmenter_unit verification clean");
    else
      $display("moving_average_object_segmenter_unit verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/maseg_pkg.sv
rtl/maseg_result_queue.sv
rtl/moving_average_object_segmenter_unit.sv
test/moving_average_object_segmenter_unit_test.sv
